### hdl/workload_lease_table_macros.svh
// ----------------------------------------------------------------------------
// Workload lease table assertion macros
// Concurrent check wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WORKLOAD_LEASE_TABLE_MACROS_SVH
`define WORKLOAD_LEASE_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define WLT_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lease table check failed");
`define WLT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lease table check failed");
`else
`define WLT_ASSERT_IMPL(name, clk, rst, ante, cons)
`define WLT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

### hdl/wlt_pkg.sv
// ----------------------------------------------------------------------------
// Workload lease table package
// Request and response codes, field widths and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package wlt_pkg;

   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int ID_W       = 8;
   localparam int CNT_OUT_W  = 9;
   localparam int CSR_W      = 9;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - ID_W - 2 * CNT_OUT_W - 1;

   localparam logic [MODE_W-1:0] MODE_ASSIGN  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RESTORE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FINISH  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ID    = 2'd2;

   typedef struct packed {
      logic load_req;
      logic clr_en;
      logic rd_start;
      logic scan_eval;
      logic fin_eval;
      logic rsp_load;
   } wlt_cmd_type;

   typedef struct packed {
      logic go_scan;
      logic go_fin;
      logic scan_done;
      logic clear_last;
      logic rsp_free;
   } wlt_status_type;

endpackage

`default_nettype wire

### hdl/wlt_controller.sv
// ----------------------------------------------------------------------------
// Workload lease table controller
// Sequences table clearing, request intake, entry scans and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module wlt_controller import wlt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_wen,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  wlt_status_type dp_status,
   output wlt_cmd_type    dp_cmd
);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_START = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_FIN   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            dp_cmd.clr_en = 1'b1;
            if (dp_status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               dp_cmd.load_req = 1'b1;
               state_in        = ST_START;
            end
         end
         ST_START: begin
            dp_cmd.rd_start = 1'b1;
            if (dp_status.go_scan) begin
               state_in = ST_SCAN;
            end else if (dp_status.go_fin) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            dp_cmd.scan_eval = 1'b1;
            if (dp_status.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_FIN: begin
            dp_cmd.fin_eval = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (dp_status.rsp_free) begin
               dp_cmd.rsp_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      if (csr_wen) begin
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### hdl/wlt_datapath.sv
// ----------------------------------------------------------------------------
// Workload lease table datapath
// Entry memory, request registers, scan pointer, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wlt_datapath import wlt_pkg::*; #(
   parameter int MAX_WORKLOADS = 256,
   parameter int NODE_BITS     = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_W-1:0]      csr_wdata,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [NODE_BITS-1:0]  req_node,
   input  logic [ID_W-1:0]       req_entry_id,
   input  wlt_cmd_type           dp_cmd,
   output wlt_status_type        dp_status,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [RSP_DATA_W-1:0] rsp_data
);

   localparam int AW      = $clog2(MAX_WORKLOADS);
   localparam int CW      = $clog2(MAX_WORKLOADS + 1);
   localparam int NW      = (CW > CSR_W) ? CW : CSR_W;
   localparam int XW      = (CW > ID_W) ? CW : ID_W;
   localparam int OW      = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
   localparam int GW      = (AW > ID_W) ? AW : ID_W;
   localparam int EW      = NODE_BITS + 2;
   localparam int ASG_BIT = NODE_BITS + 1;
   localparam int FIN_BIT = NODE_BITS;

   logic [EW-1:0]         lease_mem_ff [MAX_WORKLOADS];
   logic [EW-1:0]         rdata_ff;
   logic [AW-1:0]         chk_ff;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [EW-1:0]         wr_data;

   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [NODE_BITS-1:0]  node_ff, node_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [CW-1:0]         n_ff, n_in;
   logic [CW-1:0]         done_ff, done_in;
   logic [CW-1:0]         released_ff, released_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [AW-1:0]         grant_ff, grant_in;
   logic                  found_ff, found_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [NW-1:0]         num_ext;
   logic [XW-1:0]         id_ext;
   logic [GW-1:0]         grant_wide;
   logic [OW-1:0]         rel_wide;
   logic [OW-1:0]         done_wide;
   logic                  is_assign, is_restore, is_finish;
   logic                  id_bad, n_zero, scan_last;
   logic                  entry_asg, entry_fin;
   logic [NODE_BITS-1:0]  entry_owner;
   logic                  take, drop, mark, all_done;

   always_comb begin
      num_ext     = NW'(csr_wdata);
      id_ext      = XW'(id_ff);
      is_assign   = (mode_ff == MODE_ASSIGN);
      is_restore  = (mode_ff == MODE_RESTORE);
      is_finish   = (mode_ff == MODE_FINISH);
      id_bad      = (id_ext >= XW'(n_ff));
      n_zero      = (n_ff == '0);
      scan_last   = (CW'(chk_ff) == (n_ff - CW'(1)));
      entry_asg   = rdata_ff[ASG_BIT];
      entry_fin   = rdata_ff[FIN_BIT];
      entry_owner = rdata_ff[NODE_BITS-1:0];
      take        = dp_cmd.scan_eval && is_assign && !entry_asg;
      drop        = dp_cmd.scan_eval && is_restore && entry_asg && !entry_fin
                    && (entry_owner == node_ff);
      mark        = dp_cmd.fin_eval && !entry_fin;
      all_done    = (done_ff >= n_ff);

      dp_status.go_scan    = (is_assign || is_restore) && !n_zero;
      dp_status.go_fin     = is_finish && !id_bad;
      dp_status.scan_done  = scan_last || take;
      dp_status.clear_last = (clr_ff == AW'(MAX_WORKLOADS - 1));
      dp_status.rsp_free   = !rsp_valid_ff || rsp_tready;

      if (dp_cmd.rd_start) begin
         rd_addr = is_finish ? id_ext[AW-1:0] : '0;
      end else begin
         rd_addr = chk_ff + AW'(1);
      end

      wr_en   = 1'b0;
      wr_addr = chk_ff;
      wr_data = rdata_ff;
      if (dp_cmd.clr_en) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (take) begin
         wr_en   = 1'b1;
         wr_data = {1'b1, entry_fin, node_ff};
      end else if (drop) begin
         wr_en   = 1'b1;
         wr_data = {1'b0, entry_fin, entry_owner};
      end else if (mark) begin
         wr_en   = 1'b1;
         wr_data = {entry_asg, 1'b1, entry_owner};
      end

      mode_in = dp_cmd.load_req ? req_mode : mode_ff;
      node_in = dp_cmd.load_req ? req_node : node_ff;
      id_in   = dp_cmd.load_req ? req_entry_id : id_ff;

      n_in = n_ff;
      if (csr_wen) begin
         n_in = (num_ext > NW'(MAX_WORKLOADS)) ? CW'(MAX_WORKLOADS) : num_ext[CW-1:0];
      end

      if (csr_wen) begin
         clr_in = '0;
      end else if (dp_cmd.clr_en) begin
         clr_in = clr_ff + AW'(1);
      end else begin
         clr_in = clr_ff;
      end

      if (csr_wen) begin
         done_in = '0;
      end else if (mark) begin
         done_in = done_ff + CW'(1);
      end else begin
         done_in = done_ff;
      end

      if (dp_cmd.load_req) begin
         found_in    = 1'b0;
         released_in = '0;
      end else begin
         found_in    = found_ff || take;
         released_in = drop ? (released_ff + CW'(1)) : released_ff;
      end
      grant_in = take ? chk_ff : grant_ff;

      if (is_assign && !found_ff) begin
         rsp_status_in = STATUS_NONE_FREE;
      end else if (is_finish && id_bad) begin
         rsp_status_in = STATUS_BAD_ID;
      end else begin
         rsp_status_in = STATUS_OK;
      end
      grant_wide  = found_ff ? GW'(grant_ff) : '0;
      rel_wide    = OW'(released_ff);
      done_wide   = OW'(done_ff);
      rsp_data_in = {RSP_PAD_W'(0), all_done, done_wide[CNT_OUT_W-1:0],
                     rel_wide[CNT_OUT_W-1:0], grant_wide[ID_W-1:0]};

      if (dp_cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lease_mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= lease_mem_ff[rd_addr];
      chk_ff   <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         done_ff      <= '0;
         clr_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_ff         <= n_in;
         done_ff      <= done_in;
         clr_ff       <= clr_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      node_ff     <= node_in;
      id_ff       <= id_in;
      released_ff <= released_in;
      grant_ff    <= grant_in;
      if (dp_cmd.rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

### hdl/workload_lease_table.sv
// ----------------------------------------------------------------------------
// Workload lease table
// Grants, restores and finishes workload entries for a pool of nodes.
//
// req_* carries one request: tuser is the mode (assign, restore, finish),
// tdata the node and the entry id. rsp_* returns one result per request:
// tuser is the status, tdata the granted id, released count, finished count
// and the all-done flag. csr_wen/csr_wdata write the entry count.
// A request is taken only in idle. A finish reads its entry, marks it finished
// if it was not and then returns its result; an out-of-range finish, an unused
// mode and any request to an empty table go straight to the result. Assign
// and restore walk the entry memory one entry per cycle through its single
// read port: restore walks all n entries, assign stops at the lowest free
// entry and walks all n entries when none is free.
// Reset and every csr write clear the table in a pass over all MAX_WORKLOADS
// entries; req_tready stays low meanwhile. A stalled rsp holds its result in
// the output register; the next request is accepted meanwhile and its result
// waits in the datapath until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "workload_lease_table_macros.svh"

module workload_lease_table import wlt_pkg::*; #(
   parameter int MAX_WORKLOADS = 256,
   parameter int NODE_BITS     = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wen,
   input  logic [CSR_W-1:0]                        csr_wdata,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // mode
   input  logic [MODE_W-1:0]                       req_tuser,
   // node, entry_id
   input  logic [((NODE_BITS+ID_W+7)/8)*8-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // status
   output logic [STATUS_W-1:0]                     rsp_tuser,
   // workload_id, released_count, finished_count, all_done
   output logic [RSP_DATA_W-1:0]                   rsp_tdata
);

   wlt_cmd_type    ctl_cmd;
   wlt_status_type dp_status;

   wlt_controller u_ctl (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .dp_cmd     (ctl_cmd)
   );

   wlt_datapath #(
      .MAX_WORKLOADS (MAX_WORKLOADS),
      .NODE_BITS     (NODE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_wdata    (csr_wdata),
      .req_mode     (req_tuser),
      .req_node     (req_tdata[NODE_BITS-1:0]),
      .req_entry_id (req_tdata[NODE_BITS+ID_W-1:NODE_BITS]),
      .dp_cmd       (ctl_cmd),
      .dp_status    (dp_status),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_status   (rsp_tuser),
      .rsp_data     (rsp_tdata)
   );

   `WLT_ASSERT_NEXT(a_single_request, clock, reset, req_tvalid && req_tready, !req_tready)
   `WLT_ASSERT_IMPL(a_load_when_free, clock, reset, ctl_cmd.rsp_load, dp_status.rsp_free)
   `WLT_ASSERT_NEXT(a_csr_starts_clear, clock, reset, csr_wen, !req_tready)
   `WLT_ASSERT_IMPL(a_clear_exclusive, clock, reset, ctl_cmd.clr_en, !ctl_cmd.scan_eval && !ctl_cmd.fin_eval && !req_tready)

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Workload lease table testbench
// Drives assign, restore and finish requests over a range of job sizes,
// predicts every response from a local copy of the table and compares it
// field by field. Both stream sides idle at random in two of three mixes.
// ----------------------------------------------------------------------------
module testbench import wlt_pkg::*; ();

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int TABLE_DEPTH = 256;
   localparam int NODE_W      = 16;
   localparam int REQ_DATA_W  = ((NODE_W + ID_W + 7) / 8) * 8;
   localparam int CSR_MAX     = (1 << CSR_W) - 1;

   typedef struct {
      logic [STATUS_W-1:0]  status;
      logic [ID_W-1:0]      workload_id;
      logic [CNT_OUT_W-1:0] released;
      logic [CNT_OUT_W-1:0] finished;
      logic                 all_done;
   } lease_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wen;
   logic [CSR_W-1:0]      csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   // mode
   logic [MODE_W-1:0]     req_tuser;
   // node, entry_id
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // status
   logic [STATUS_W-1:0]   rsp_tuser;
   // workload_id, released_count, finished_count, all_done
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int            job_size;
   logic          lease_assigned [TABLE_DEPTH];
   logic          lease_finished [TABLE_DEPTH];
   logic [NODE_W-1:0] lease_owner [TABLE_DEPTH];
   int            done_total;

   lease_result_type expected_leases [$];
   lease_result_type got_lease;
   lease_result_type want_lease;
   int            mismatch_count;
   int            send_idle_pct;
   int            recv_idle_pct;

   workload_lease_table DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("testbench: errors");
      $finish;
   end

   function automatic void clear_job(input int size_value);
      job_size   = size_value;
      done_total = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         lease_assigned[i] = 1'b0;
         lease_finished[i] = 1'b0;
         lease_owner[i]    = '0;
      end
   endfunction

   function automatic lease_result_type predict_lease(input logic [MODE_W-1:0] mode,
                                                      input logic [NODE_W-1:0] node,
                                                      input logic [ID_W-1:0] entry_id);
      lease_result_type r;
      int            n;
      int            released;
      n           = (job_size > TABLE_DEPTH) ? TABLE_DEPTH : job_size;
      released    = 0;
      r.status      = STATUS_OK;
      r.workload_id = '0;
      case (mode)
         MODE_ASSIGN: begin
            r.status = STATUS_NONE_FREE;
            for (int i = 0; i < n; i++) begin
               if (r.status == STATUS_NONE_FREE && !lease_assigned[i]) begin
                  lease_assigned[i] = 1'b1;
                  lease_owner[i]    = node;
                  r.workload_id     = ID_W'(i);
                  r.status          = STATUS_OK;
               end
            end
         end
         MODE_RESTORE: begin
            for (int i = 0; i < n; i++) begin
               if (lease_assigned[i] && !lease_finished[i] && lease_owner[i] == node) begin
                  lease_assigned[i] = 1'b0;
                  released++;
               end
            end
         end
         MODE_FINISH: begin
            if (int'(entry_id) >= n) begin
               r.status = STATUS_BAD_ID;
            end else if (!lease_finished[entry_id]) begin
               lease_finished[entry_id] = 1'b1;
               done_total++;
            end
         end
         default: begin
         end
      endcase
      r.released = CNT_OUT_W'(released);
      r.finished = CNT_OUT_W'(done_total);
      r.all_done = (done_total >= n);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input lease_result_type want,
                                  input lease_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected st=%0d id=%0d rel=%0d fin=%0d done=%0d, ",
                  $realtime, what, want.status, want.workload_id, want.released,
                  want.finished, want.all_done,
                  "got st=%0d id=%0d rel=%0d fin=%0d done=%0d",
                  got.status, got.workload_id, got.released, got.finished,
                  got.all_done);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_lease.status      = rsp_tuser;
         got_lease.workload_id = rsp_tdata[ID_W-1:0];
         got_lease.released    = rsp_tdata[ID_W +: CNT_OUT_W];
         got_lease.finished    = rsp_tdata[ID_W+CNT_OUT_W +: CNT_OUT_W];
         got_lease.all_done    = rsp_tdata[ID_W+2*CNT_OUT_W];
         if (expected_leases.size() == 0) begin
            report_mismatch("response with nothing pending", got_lease, got_lease);
         end else begin
            want_lease = expected_leases.pop_front();
            if (got_lease.status !== want_lease.status ||
                got_lease.workload_id !== want_lease.workload_id ||
                got_lease.released !== want_lease.released ||
                got_lease.finished !== want_lease.finished ||
                got_lease.all_done !== want_lease.all_done)
               report_mismatch("response mismatch", want_lease, got_lease);
         end
      end
   end

   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [NODE_W-1:0] node,
                               input logic [ID_W-1:0] entry_id);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_DATA_W'({entry_id, node});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_leases.push_back(predict_lease(mode, node, entry_id));
   endtask

   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (expected_leases.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_job_size(input int size_value);
      drain_requests();
      csr_wen   <= 1'b1;
      csr_wdata <= CSR_W'(size_value);
      @(posedge clock);
      csr_wen   <= 1'b0;
      clear_job(size_value);
   endtask

   task automatic test_empty_table();
      set_job_size(0);
      send_request(MODE_ASSIGN, 16'h0000, 8'h00);
      send_request(MODE_FINISH, 16'h0000, 8'h00);
      send_request(MODE_RESTORE, 16'hFFFF, 8'hFF);
      send_request(MODE_UNUSED, 16'hFFFF, 8'hFF);
      set_job_size(1);
      send_request(MODE_FINISH, 16'h1234, 8'h00);
   endtask

   task automatic test_assign_finish();
      set_job_size(3);
      repeat (4) send_request(MODE_ASSIGN, 16'hFFFF, 8'h00);
      send_request(MODE_FINISH, 16'h0000, 8'h01);
      send_request(MODE_FINISH, 16'h0000, 8'h01);
      send_request(MODE_FINISH, 16'h0000, 8'h03);
      send_request(MODE_FINISH, 16'h0000, 8'hFF);
   endtask

   task automatic test_restore();
      set_job_size(4);
      send_request(MODE_FINISH, 16'h0000, 8'h03);
      send_request(MODE_ASSIGN, 16'hA5A5, 8'h00);
      send_request(MODE_ASSIGN, 16'h5A5A, 8'h00);
      send_request(MODE_ASSIGN, 16'hA5A5, 8'h00);
      send_request(MODE_FINISH, 16'h0000, 8'h02);
      send_request(MODE_RESTORE, 16'hA5A5, 8'h00);
      send_request(MODE_ASSIGN, 16'h5A5A, 8'h00);
      send_request(MODE_ASSIGN, 16'hA5A5, 8'h00);
      send_request(MODE_RESTORE, 16'h5A5A, 8'h00);
   endtask

   task automatic test_oversized_count();
      set_job_size(CSR_MAX);
      send_request(MODE_FINISH, 16'h0000, 8'hFF);
      send_request(MODE_ASSIGN, 16'h8001, 8'h00);
      send_request(MODE_RESTORE, 16'h8001, 8'h00);
      set_job_size(TABLE_DEPTH);
      send_request(MODE_ASSIGN, 16'h7FFE, 8'h00);
   endtask

   task automatic test_random_jobs(input int send_pct, input int recv_pct, input int total);
      int                sent;
      int                job_items;
      int                size_value;
      int                n_eff;
      int                pick;
      logic [NODE_W-1:0] pool [4];
      logic [NODE_W-1:0] node;
      logic [ID_W-1:0]   entry_id;
      logic [MODE_W-1:0] mode;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < total) begin
         pick = $urandom_range(0, 99);
         if (pick < 6)
            size_value = TABLE_DEPTH;
         else if (pick < 9)
            size_value = $urandom_range(TABLE_DEPTH + 1, CSR_MAX);
         else if (pick < 12)
            size_value = 0;
         else
            size_value = $urandom_range(1, 24);
         set_job_size(size_value);
         n_eff = (size_value > TABLE_DEPTH) ? TABLE_DEPTH : size_value;
         for (int k = 0; k < 4; k++) pool[k] = NODE_W'($urandom_range(0, 65535));
         job_items = (n_eff == TABLE_DEPTH) ? 30 : $urandom_range(20, 60);
         for (int k = 0; k < job_items && sent < total; k++) begin
            node = ($urandom_range(0, 9) == 0) ? NODE_W'($urandom) : pool[$urandom_range(0, 3)];
            entry_id = (n_eff > 0 && $urandom_range(0, 9) != 0) ?
                       ID_W'($urandom_range(0, n_eff - 1)) : ID_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45)
               mode = MODE_ASSIGN;
            else if (pick < 70)
               mode = MODE_FINISH;
            else if (pick < 92)
               mode = MODE_RESTORE;
            else
               mode = MODE_UNUSED;
            send_request(mode, node, entry_id);
            sent++;
         end
      end
   endtask

   initial begin
      reset      <= 1'b1;
      csr_wen    <= 1'b0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tuser  <= '0;
      req_tdata  <= '0;
      mismatch_count = 0;
      send_idle_pct  = 33;
      recv_idle_pct  = 53;
      clear_job(0);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_assign_finish();
      test_restore();
      test_oversized_count();
      test_random_jobs(33, 53, 633);
      test_random_jobs(53, 33, 633);
      test_random_jobs(0, 0, 634);

      drain_requests();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
